// ===== sv/hht_pkg.sv =====
// Package for the HTML highlight tokenizer: lexer modes, marker codes,
// the result and front-to-back batch structs. No dependencies.
package hht_pkg;

   typedef enum logic [16:0] {
      M_NORMAL      = 17'h00001,
      M_TAG         = 17'h00002,
      M_TAG2        = 17'h00004,
      M_EXCL        = 17'h00008,
      M_EXCL_HY     = 17'h00010,
      M_KEY         = 17'h00020,
      M_VAL         = 17'h00040,
      M_QUOTE       = 17'h00080,
      M_DQUOTE      = 17'h00100,
      M_COMMENT     = 17'h00200,
      M_COMMENT_HY  = 17'h00400,
      M_COMMENT_HY2 = 17'h00800,
      M_RELAY       = 17'h01000,
      M_QUES        = 17'h02000,
      M_QUES_P      = 17'h04000,
      M_QUES_PH     = 17'h08000,
      M_ENTITY      = 17'h10000
   } mode_type;

   localparam logic [7:0] MK_RESET     = 8'd0;
   localparam logic [7:0] MK_ENTITY    = 8'd1;
   localparam logic [7:0] MK_TAG       = 8'd2;
   localparam logic [7:0] MK_ATTRIB    = 8'd3;
   localparam logic [7:0] MK_COMMENT   = 8'd4;
   localparam logic [7:0] MK_STRING    = 8'd5;
   localparam logic [7:0] MK_EMBED_END = 8'd6;

   localparam logic [1:0] LANG_NONE   = 2'd0;
   localparam logic [1:0] LANG_SCRIPT = 2'd1;
   localparam logic [1:0] LANG_STYLE  = 2'd2;
   localparam logic [1:0] LANG_PHP    = 2'd3;

   localparam int MAX_RES = 11;

   // One emitted result: marker flag, value, language.
   typedef struct packed {
      logic       mark;
      logic [7:0] value;
      logic [1:0] lang;
   } res_type;

   // A whole item's result list, handed from front to back.
   typedef struct packed {
      logic [3:0]              count;
      res_type [MAX_RES-1:0]   items;
   } batch_type;

endpackage

// ===== sv/hht_front.sv =====
// Front end of the HTML highlight tokenizer: lexer state machine that turns
// one request into a batch of results. Depends on hht_pkg.
module hht_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_cmd,
   input  logic [7:0]          in_byte,
   output hht_pkg::batch_type  batch
);

   hht_pkg::mode_type mode_ff, mode_in;
   logic [7:0] name_ff [6];
   logic [2:0] nlen_ff, nlen_in;
   logic [1:0] kind_ff, kind_in;
   logic [3:0] midx_ff, midx_in;
   logic [7:0] held_ff [8];
   logic       name_we, held_we;

   hht_pkg::batch_type b;
   logic [7:0] lc;
   logic       sp;

   function automatic logic [7:0] lower(input logic [7:0] c);
      lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] closer_ch(input logic [1:0] k, input logic [3:0] i);
      logic [7:0] r;
      r = 8'h00;
      case (k)
         hht_pkg::LANG_SCRIPT: begin
            case (i)
               4'd0: r = "<"; 4'd1: r = "/"; 4'd2: r = "s"; 4'd3: r = "c";
               4'd4: r = "r"; 4'd5: r = "i"; 4'd6: r = "p"; 4'd7: r = "t";
               4'd8: r = ">"; default: r = 8'h00;
            endcase
         end
         hht_pkg::LANG_STYLE: begin
            case (i)
               4'd0: r = "<"; 4'd1: r = "/"; 4'd2: r = "s"; 4'd3: r = "t";
               4'd4: r = "y"; 4'd5: r = "l"; 4'd6: r = "e"; 4'd7: r = ">";
               default: r = 8'h00;
            endcase
         end
         hht_pkg::LANG_PHP: begin
            case (i)
               4'd0: r = "?"; 4'd1: r = ">"; default: r = 8'h00;
            endcase
         end
         default: r = 8'h00;
      endcase
      closer_ch = r;
   endfunction

   function automatic logic [3:0] closer_len(input logic [1:0] k);
      case (k)
         hht_pkg::LANG_SCRIPT: closer_len = 4'd9;
         hht_pkg::LANG_STYLE:  closer_len = 4'd8;
         hht_pkg::LANG_PHP:    closer_len = 4'd2;
         default:              closer_len = 4'd0;
      endcase
   endfunction

   // Appends one result to the batch under construction.
   function automatic hht_pkg::batch_type put(input hht_pkg::batch_type bi, input logic m,
                                               input logic [7:0] v, input logic [1:0] l);
      hht_pkg::batch_type bo;
      bo = bi;
      if (bi.count < 4'(hht_pkg::MAX_RES)) begin
         bo.items[bi.count] = '{mark: m, value: v, lang: l};
         bo.count = bi.count + 4'd1;
      end
      put = bo;
   endfunction

   logic is_script, is_style;
   always_comb begin
      is_script = nlen_ff == 3'd6 && name_ff[0] == "s" && name_ff[1] == "c" &&
                  name_ff[2] == "r" && name_ff[3] == "i" && name_ff[4] == "p" &&
                  name_ff[5] == "t";
      is_style  = nlen_ff == 3'd5 && name_ff[0] == "s" && name_ff[1] == "t" &&
                  name_ff[2] == "y" && name_ff[3] == "l" && name_ff[4] == "e";
   end

   always_comb begin
      b = '0;
      mode_in = mode_ff;
      nlen_in = nlen_ff;
      kind_in = kind_ff;
      midx_in = midx_ff;
      name_we = 1'b0;
      held_we = 1'b0;
      lc = lower(in_byte);
      sp = in_byte == 8'h20 || (in_byte >= 8'd9 && in_byte <= 8'd13);
      if (in_cmd) begin
         case (mode_ff)
            hht_pkg::M_TAG: b = put(b, 1'b0, "<", 2'd0);
            hht_pkg::M_EXCL: begin
               b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "!", 2'd0);
            end
            hht_pkg::M_EXCL_HY: begin
               b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "!", 2'd0);
               b = put(b, 1'b0, "-", 2'd0);
            end
            hht_pkg::M_QUES: begin
               b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
            end
            hht_pkg::M_QUES_P: begin
               b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
               b = put(b, 1'b0, "p", 2'd0);
            end
            hht_pkg::M_QUES_PH: begin
               b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
               b = put(b, 1'b0, "p", 2'd0); b = put(b, 1'b0, "h", 2'd0);
            end
            hht_pkg::M_COMMENT, hht_pkg::M_COMMENT_HY, hht_pkg::M_COMMENT_HY2,
            hht_pkg::M_ENTITY, hht_pkg::M_DQUOTE, hht_pkg::M_QUOTE,
            hht_pkg::M_TAG2, hht_pkg::M_KEY:
               b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
            hht_pkg::M_RELAY: begin
               for (int j = 0; j < 8; j++)
                  if (4'(j) < midx_ff) b = put(b, 1'b0, held_ff[j], kind_ff);
               b = put(b, 1'b1, hht_pkg::MK_EMBED_END, kind_ff);
            end
            default: ;
         endcase
         mode_in = hht_pkg::M_NORMAL;
         nlen_in = 3'd0;
         kind_in = 2'd0;
         midx_in = 4'd0;
      end else begin
         case (mode_ff)
            hht_pkg::M_ENTITY: begin
               b = put(b, 1'b0, in_byte, 2'd0);
               if (in_byte == ";") begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end
            end
            hht_pkg::M_TAG: begin
               if (in_byte == "!") mode_in = hht_pkg::M_EXCL;
               else if (in_byte == "?") mode_in = hht_pkg::M_QUES;
               else if (in_byte == ">" || sp) begin
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end else begin
                  b = put(b, 1'b0, "<", 2'd0);
                  b = put(b, 1'b1, hht_pkg::MK_TAG, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  name_we = nlen_ff < 3'd6;
                  nlen_in = nlen_ff < 3'd6 ? nlen_ff + 3'd1 : 3'd7;
                  mode_in = hht_pkg::M_TAG2;
               end
            end
            hht_pkg::M_TAG2: begin
               if (in_byte == ">") begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
                  if (is_script) begin
                     kind_in = hht_pkg::LANG_SCRIPT; midx_in = 4'd0;
                     mode_in = hht_pkg::M_RELAY;
                  end else if (is_style) begin
                     kind_in = hht_pkg::LANG_STYLE; midx_in = 4'd0;
                     mode_in = hht_pkg::M_RELAY;
                  end
               end else if (sp) begin
                  b = put(b, 1'b0, in_byte, 2'd0);
                  b = put(b, 1'b1, hht_pkg::MK_ATTRIB, 2'd0);
                  mode_in = hht_pkg::M_KEY;
               end else begin
                  b = put(b, 1'b0, in_byte, 2'd0);
                  name_we = nlen_ff < 3'd6;
                  nlen_in = nlen_ff < 3'd6 ? nlen_ff + 3'd1 : 3'd7;
               end
            end
            hht_pkg::M_EXCL: begin
               if (in_byte == "-") mode_in = hht_pkg::M_EXCL_HY;
               else begin
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "!", 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end
            end
            hht_pkg::M_EXCL_HY: begin
               if (in_byte == "-") begin
                  b = put(b, 1'b1, hht_pkg::MK_COMMENT, 2'd0);
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "!", 2'd0);
                  b = put(b, 1'b0, "-", 2'd0); b = put(b, 1'b0, "-", 2'd0);
                  mode_in = hht_pkg::M_COMMENT;
               end else begin
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "!", 2'd0);
                  b = put(b, 1'b0, "-", 2'd0); b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end
            end
            hht_pkg::M_COMMENT: begin
               b = put(b, 1'b0, in_byte, 2'd0);
               if (in_byte == "-") mode_in = hht_pkg::M_COMMENT_HY;
            end
            hht_pkg::M_COMMENT_HY: begin
               b = put(b, 1'b0, in_byte, 2'd0);
               mode_in = (in_byte == "-") ? hht_pkg::M_COMMENT_HY2 : hht_pkg::M_COMMENT;
            end
            hht_pkg::M_COMMENT_HY2: begin
               b = put(b, 1'b0, in_byte, 2'd0);
               if (in_byte == ">") begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end else if (in_byte != "-") mode_in = hht_pkg::M_COMMENT;
            end
            hht_pkg::M_KEY: begin
               if (in_byte == "=") begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_VAL;
               end else if (in_byte == ">") begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
                  if (is_script) begin
                     kind_in = hht_pkg::LANG_SCRIPT; midx_in = 4'd0;
                     mode_in = hht_pkg::M_RELAY;
                  end else if (is_style) begin
                     kind_in = hht_pkg::LANG_STYLE; midx_in = 4'd0;
                     mode_in = hht_pkg::M_RELAY;
                  end
               end else b = put(b, 1'b0, in_byte, 2'd0);
            end
            hht_pkg::M_VAL: begin
               if (sp) begin
                  b = put(b, 1'b0, in_byte, 2'd0);
                  b = put(b, 1'b1, hht_pkg::MK_ATTRIB, 2'd0);
                  mode_in = hht_pkg::M_KEY;
               end else if (in_byte == 8'h27) begin
                  b = put(b, 1'b1, hht_pkg::MK_STRING, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_QUOTE;
               end else if (in_byte == 8'h22) begin
                  b = put(b, 1'b1, hht_pkg::MK_STRING, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_DQUOTE;
               end else if (in_byte == ">") begin
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
                  if (is_script) begin
                     kind_in = hht_pkg::LANG_SCRIPT; midx_in = 4'd0;
                     mode_in = hht_pkg::M_RELAY;
                  end else if (is_style) begin
                     kind_in = hht_pkg::LANG_STYLE; midx_in = 4'd0;
                     mode_in = hht_pkg::M_RELAY;
                  end
               end else b = put(b, 1'b0, in_byte, 2'd0);
            end
            hht_pkg::M_QUOTE: begin
               b = put(b, 1'b0, in_byte, 2'd0);
               if (in_byte == 8'h27) begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  mode_in = hht_pkg::M_VAL;
               end
            end
            hht_pkg::M_DQUOTE: begin
               b = put(b, 1'b0, in_byte, 2'd0);
               if (in_byte == 8'h22) begin
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  mode_in = hht_pkg::M_VAL;
               end
            end
            hht_pkg::M_RELAY: begin
               if (midx_ff < closer_len(kind_ff) && closer_ch(kind_ff, midx_ff) == lc) begin
                  if (midx_ff + 4'd1 == closer_len(kind_ff)) begin
                     if (kind_ff == hht_pkg::LANG_PHP) begin
                        for (int j = 0; j < 8; j++)
                           if (4'(j) < midx_ff) b = put(b, 1'b0, held_ff[j], 2'd0);
                        b = put(b, 1'b0, in_byte, 2'd0);
                     end else begin
                        b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "/", 2'd0);
                        b = put(b, 1'b1, hht_pkg::MK_TAG, 2'd0);
                        if (kind_ff == hht_pkg::LANG_SCRIPT) begin
                           b = put(b, 1'b0, "s", 2'd0); b = put(b, 1'b0, "c", 2'd0);
                           b = put(b, 1'b0, "r", 2'd0); b = put(b, 1'b0, "i", 2'd0);
                           b = put(b, 1'b0, "p", 2'd0); b = put(b, 1'b0, "t", 2'd0);
                        end else begin
                           b = put(b, 1'b0, "s", 2'd0); b = put(b, 1'b0, "t", 2'd0);
                           b = put(b, 1'b0, "y", 2'd0); b = put(b, 1'b0, "l", 2'd0);
                           b = put(b, 1'b0, "e", 2'd0);
                        end
                        b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                        b = put(b, 1'b0, ">", 2'd0);
                     end
                     mode_in = hht_pkg::M_NORMAL;
                     kind_in = 2'd0;
                     midx_in = 4'd0;
                  end else if (midx_ff < 4'd8) begin
                     held_we = 1'b1;
                     midx_in = midx_ff + 4'd1;
                  end
               end else begin
                  for (int j = 0; j < 8; j++)
                     if (4'(j) < midx_ff) b = put(b, 1'b0, held_ff[j], kind_ff);
                  b = put(b, 1'b0, in_byte, kind_ff);
                  midx_in = 4'd0;
               end
            end
            hht_pkg::M_QUES: begin
               if (in_byte == "p") mode_in = hht_pkg::M_QUES_P;
               else if (in_byte == "=") begin
                  b = put(b, 1'b1, hht_pkg::MK_TAG, 2'd0);
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
                  b = put(b, 1'b0, "=", 2'd0);
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  kind_in = hht_pkg::LANG_PHP; midx_in = 4'd0;
                  mode_in = hht_pkg::M_RELAY;
               end else begin
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end
            end
            hht_pkg::M_QUES_P: begin
               if (in_byte == "h") mode_in = hht_pkg::M_QUES_PH;
               else begin
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
                  b = put(b, 1'b0, "p", 2'd0); b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end
            end
            hht_pkg::M_QUES_PH: begin
               if (in_byte == "p") begin
                  b = put(b, 1'b0, "<", 2'd0);
                  b = put(b, 1'b1, hht_pkg::MK_TAG, 2'd0);
                  b = put(b, 1'b0, "?", 2'd0); b = put(b, 1'b0, "p", 2'd0);
                  b = put(b, 1'b0, "h", 2'd0); b = put(b, 1'b0, "p", 2'd0);
                  b = put(b, 1'b1, hht_pkg::MK_RESET, 2'd0);
                  kind_in = hht_pkg::LANG_PHP; midx_in = 4'd0;
                  mode_in = hht_pkg::M_RELAY;
               end else begin
                  b = put(b, 1'b0, "<", 2'd0); b = put(b, 1'b0, "?", 2'd0);
                  b = put(b, 1'b0, "p", 2'd0); b = put(b, 1'b0, "h", 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
                  mode_in = hht_pkg::M_NORMAL;
               end
            end
            default: begin
               if (in_byte == "<") begin
                  mode_in = hht_pkg::M_TAG;
                  nlen_in = 3'd0;
               end else if (in_byte == "&") begin
                  mode_in = hht_pkg::M_ENTITY;
                  b = put(b, 1'b1, hht_pkg::MK_ENTITY, 2'd0);
                  b = put(b, 1'b0, in_byte, 2'd0);
               end else b = put(b, 1'b0, in_byte, 2'd0);
            end
         endcase
      end
      batch = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hht_pkg::M_NORMAL;
         nlen_ff <= 3'd0;
         kind_ff <= 2'd0;
         midx_ff <= 4'd0;
      end else if (in_valid) begin
         mode_ff <= mode_in;
         nlen_ff <= nlen_in;
         kind_ff <= kind_in;
         midx_ff <= midx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && name_we) name_ff[nlen_ff[2:0] < 3'd6 ? nlen_ff : 3'd0] <= lc;
      if (in_valid && held_we) held_ff[midx_ff[2:0]] <= in_byte;
   end

endmodule

// ===== sv/hht_back.sv =====
// Back end of the HTML highlight tokenizer: a two-entry batch queue and an
// output sequencer that hands results out one per pop. Depends on hht_pkg.
module hht_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  hht_pkg::batch_type  wr_batch,
   output logic                q_full,
   output logic                empty,
   input  logic                pop,
   output logic                is_marker,
   output logic [7:0]          out_value,
   output logic [1:0]          embed_lang,
   output logic                last_of_run
);

   hht_pkg::batch_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [3:0] pos_ff, pos_in;
   logic       rd_done;
   hht_pkg::res_type cur;

   assign q_full = cnt_ff == 2'd2;
   assign empty  = cnt_ff == 2'd0;
   assign cur    = q_ff[rp_ff].items[pos_ff];
   assign is_marker   = cur.mark;
   assign out_value   = cur.value;
   assign embed_lang  = cur.lang;
   assign last_of_run = pos_ff + 4'd1 == q_ff[rp_ff].count;

   always_comb begin
      rd_done = !empty && pop && last_of_run;
      wp_in  = wp_ff ^ wr_en;
      rp_in  = rp_ff ^ rd_done;
      cnt_in = cnt_ff + {1'b0, wr_en} - {1'b0, rd_done};
      pos_in = rd_done ? 4'd0 : (!empty && pop) ? pos_ff + 4'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
         pos_ff <= 4'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) q_ff[wp_ff] <= wr_batch;
   end

endmodule

// ===== sv/html_highlight_tokenizer_unit.sv =====
// Top level of the HTML highlight tokenizer: lexer front end feeding a
// batch queue and output sequencer. Depends on hht_pkg, hht_front, hht_back.
//
//   channel   | handshake        | payload
//   ----------+------------------+-------------------------------------------
//   request   | req_push/req_full| req_cmd, req_text_byte
//   response  | rsp_pop/rsp_empty| rsp_is_marker, rsp_out_value,
//             |                  | rsp_embed_lang, rsp_last_of_run
//
// Each accepted request is lexed in its cycle and its whole result list (0 to
// 11 results) is written into a two-entry queue. The sequencer gives one
// result per cycle while rsp_pop is high. Requests that yield nothing go
// straight through without using the queue.
// Reset is synchronous and clears the lexer mode, counters and queue.
// The request side stalls (req_full) only when both queue entries hold lists.
module html_highlight_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_cmd,
   input  logic [7:0] req_text_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_is_marker,
   output logic [7:0] rsp_out_value,
   output logic [1:0] rsp_embed_lang,
   output logic       rsp_last_of_run
);

   hht_pkg::batch_type batch;
   logic accept;

   // A request is taken whenever the queue has a free entry.
   assign accept = req_push && !req_full;

   hht_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_cmd   (req_cmd),
      .in_byte  (req_text_byte),
      .batch    (batch)
   );

   // Only non-empty lists occupy a queue entry.
   hht_back u_back (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept && batch.count != 4'd0),
      .wr_batch    (batch),
      .q_full      (req_full),
      .empty       (rsp_empty),
      .pop         (rsp_pop),
      .is_marker   (rsp_is_marker),
      .out_value   (rsp_out_value),
      .embed_lang  (rsp_embed_lang),
      .last_of_run (rsp_last_of_run)
   );

   // A queued list never holds more results than the lexer can produce.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      accept |-> batch.count <= 4'd11)
      else $error("result list too long");

   // While results wait and are not taken, the shown result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_out_value) && $stable(rsp_is_marker))
      else $error("result changed while stalled");

   // A taken final result of a list with no new list frees an entry.
   a_free: assert property (@(posedge clock) disable iff (reset)
      req_full && rsp_pop && rsp_last_of_run |=> !req_full)
      else $error("queue entry not freed");

endmodule
